[hw/rtl/lbp_pkg.sv]
`default_nettype none
package lbp_pkg;

    localparam int MAX_BEAMS     = 2048;
    localparam int CORDIC_STEPS  = 24;
    localparam int CORDIC_LAT    = CORDIC_STEPS + 1;
    localparam int PLACE_LAT     = 3;
    localparam int NORM_BITS     = 8;
    localparam int NORM_CORE_LAT = 3 + 2 * NORM_BITS;
    localparam int NORM_PAD      = CORDIC_LAT + PLACE_LAT - NORM_CORE_LAT;
    localparam int OK_LAT        = CORDIC_LAT + PLACE_LAT;
    localparam int TOTAL_LAT     = 1 + CORDIC_LAT + PLACE_LAT;
    localparam int XW            = 34;
    localparam int ZW            = 32;
    localparam int ADDR_W        = 5;

    localparam logic signed [XW-1:0] CORDIC_GAIN_Q30 = XW'(652032874);

    localparam logic [29:0] ATAN_TURN [CORDIC_STEPS] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

    // register map, word index
    localparam logic [2:0] REG_PIXEL_SCALE  = 3'd0;
    localparam logic [2:0] REG_NEAR_LIMIT   = 3'd1;
    localparam logic [2:0] REG_FAR_LIMIT    = 3'd2;
    localparam logic [2:0] REG_REFLECT_REF  = 3'd3;
    localparam logic [2:0] REG_ANGLE_START  = 3'd4;
    localparam logic [2:0] REG_ANGLE_STEP   = 3'd5;
    localparam logic [2:0] REG_CENTER_X     = 3'd6;
    localparam logic [2:0] REG_CENTER_Y     = 3'd7;

    typedef struct packed {
        logic [10:0] beam_index;
        logic [15:0] distance_mm;
        logic [15:0] raw_intensity;
    } beam_t;

    typedef struct packed {
        logic [7:0]         norm_intensity;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
        logic               in_range;
    } pixel_t;

    function automatic logic signed [15:0] sat16(input logic signed [XW-1:0] v);
        logic signed [15:0] r;
        if (v > XW'(32767))
        begin
            r = 16'sd32767;
        end
        else if (v < -XW'(32768))
        begin
            r = -16'sd32768;
        end
        else
        begin
            r = v[15:0];
        end
        return r;
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [XW-1:0] v);
        logic signed [XW-1:0] t;
        t = (v + XW'(16384)) >>> 15;
        return sat16(t);
    endfunction

    function automatic logic signed [15:0] neg_sat(input logic signed [15:0] v);
        logic signed [15:0] r;
        if (v == -16'sd32768)
        begin
            r = 16'sd32767;
        end
        else
        begin
            r = -v;
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/lidar_beam_to_pixel.sv]
`default_nettype none
// lidar beam to image pixel converter
// input channel: a beam beat (index, range in mm, raw intensity) is taken at
// the rising edge where start is high and busy is low; busy is tied low, so
// one beam per clock is accepted without gaps
// output channel: done is high for exactly one cycle with the result beat
// on result; the receiver cannot stall, and nothing is ever held back
// the result beat is registered; throughput is one beam per cycle
// the depth is set by the input stage, the 24-stage rotation pipeline for
// sine and cosine, one output stage, and three stages of scaling, rounding
// and offset; the intensity search (8 bits, two stages a bit) runs alongside
// configuration: apb-style port, word registers at 4*index, pready always
// high, writes only while no beam is in flight (user's duty, not enforced)
// reset: all valid bits clear, registers return to their defaults; there is
// no memory, so no clearing pass
module lidar_beam_to_pixel import lbp_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire beam_t             beam,
    output logic                   done,
    output pixel_t                 result,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // configuration registers
    logic [15:0]        pixel_scale_reg;
    logic [15:0]        near_limit_reg;
    logic [15:0]        far_limit_reg;
    logic [23:0]        reflect_ref_reg;
    logic [31:0]        angle_start_reg;
    logic [31:0]        angle_step_reg;
    logic signed [15:0] center_x_reg;
    logic signed [15:0] center_y_reg;
    logic               wr_en;
    logic [2:0]         reg_sel;

    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pixel_scale_reg <= 16'd4915;
            near_limit_reg  <= 16'd100;
            far_limit_reg   <= 16'd3000;
            reflect_ref_reg <= 24'd200000;
            angle_start_reg <= 32'd0;
            angle_step_reg  <= 32'd3976821;
            center_x_reg    <= 16'sd320;
            center_y_reg    <= 16'sd320;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_PIXEL_SCALE: pixel_scale_reg <= pwdata[15:0];
                REG_NEAR_LIMIT:  near_limit_reg  <= pwdata[15:0];
                REG_FAR_LIMIT:   far_limit_reg   <= pwdata[15:0];
                REG_REFLECT_REF: reflect_ref_reg <= pwdata[23:0];
                REG_ANGLE_START: angle_start_reg <= pwdata;
                REG_ANGLE_STEP:  angle_step_reg  <= pwdata;
                REG_CENTER_X:    center_x_reg    <= pwdata[15:0];
                REG_CENTER_Y:    center_y_reg    <= pwdata[15:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_PIXEL_SCALE: prdata = {16'b0, pixel_scale_reg};
            REG_NEAR_LIMIT:  prdata = {16'b0, near_limit_reg};
            REG_FAR_LIMIT:   prdata = {16'b0, far_limit_reg};
            REG_REFLECT_REF: prdata = {8'b0, reflect_ref_reg};
            REG_ANGLE_START: prdata = angle_start_reg;
            REG_ANGLE_STEP:  prdata = angle_step_reg;
            REG_CENTER_X:    prdata = {16'b0, center_x_reg};
            REG_CENTER_Y:    prdata = {16'b0, center_y_reg};
            default:         prdata = '0;
        endcase
    end

    // never back-pressures
    assign busy = 1'b0;

    logic        accept;
    logic        s1_v_reg;
    logic [31:0] s1_ang_reg;
    logic [31:0] s1_ds_reg;
    logic        s1_ok_reg;
    logic [15:0] s1_dist_reg;
    logic [15:0] s1_raw_reg;
    logic        ok_next;
    logic [23:0] ref_eff;

    assign accept  = start && !busy;
    assign ok_next = (beam.distance_mm > near_limit_reg)
                  && (beam.distance_mm < far_limit_reg)
                  && (32'(beam.beam_index) < 32'(MAX_BEAMS));
    // a zero reference behaves as one
    assign ref_eff = (reflect_ref_reg == '0) ? 24'd1 : reflect_ref_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg <= accept;
        end
    end

    // first stage: beam angle, range times scale, window check
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_ang_reg  <= angle_start_reg
                         + 32'(angle_step_reg * {21'b0, beam.beam_index});
            s1_ds_reg   <= beam.distance_mm * pixel_scale_reg;
            s1_ok_reg   <= ok_next;
            s1_dist_reg <= beam.distance_mm;
            s1_raw_reg  <= beam.raw_intensity;
        end
    end

    logic               trig_valid;
    logic signed [15:0] sin_q15;
    logic signed [15:0] cos_q15;

    lbp_cordic u_cordic
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_v_reg),
        .angle     (s1_ang_reg),
        .out_valid (trig_valid),
        .sin_q15   (sin_q15),
        .cos_q15   (cos_q15)
    );

    // side data delayed to meet the trig results and the final stage
    logic [31:0] ds_dly_reg [CORDIC_LAT];
    logic        ok_dly_reg [OK_LAT];

    always_ff @(posedge clk)
    begin
        ds_dly_reg[0] <= s1_ds_reg;
        for (int i = 1; i < CORDIC_LAT; i++)
        begin
            ds_dly_reg[i] <= ds_dly_reg[i-1];
        end
        ok_dly_reg[0] <= s1_ok_reg;
        for (int i = 1; i < OK_LAT; i++)
        begin
            ok_dly_reg[i] <= ok_dly_reg[i-1];
        end
    end

    logic               x_valid;
    logic               y_valid;
    logic signed [15:0] pix_x;
    logic signed [15:0] pix_y;

    lbp_place u_place_x
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .ds        (ds_dly_reg[CORDIC_LAT-1]),
        .trig      (sin_q15),
        .center    (center_x_reg),
        .out_valid (x_valid),
        .pix       (pix_x)
    );

    lbp_place u_place_y
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (trig_valid),
        .ds        (ds_dly_reg[CORDIC_LAT-1]),
        .trig      (cos_q15),
        .center    (center_y_reg),
        .out_valid (y_valid),
        .pix       (pix_y)
    );

    logic       norm_valid;
    logic [7:0] norm;

    lbp_norm u_norm
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_v_reg),
        .range_mm  (s1_dist_reg),
        .raw       (s1_raw_reg),
        .ref_eff   (ref_eff),
        .out_valid (norm_valid),
        .norm      (norm)
    );

    assign done                  = x_valid;
    assign result.norm_intensity = norm;
    assign result.pixel_x        = pix_x;
    assign result.pixel_y        = pix_y;
    assign result.in_range       = ok_dly_reg[OK_LAT-1];

`ifndef SYNTH
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##TOTAL_LAT done)
        else $error("result beat missing after fixed latency");

    a_norm_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        done == norm_valid)
        else $error("intensity path out of step with pixel path");

    a_xy_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        x_valid == y_valid)
        else $error("pixel x and y paths out of step");
`endif

endmodule
`default_nettype wire

[hw/rtl/lbp_cordic.sv]
`default_nettype none
module lbp_cordic import lbp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [31:0]        angle,
    output logic                    out_valid,
    output logic signed [15:0]      sin_q15,
    output logic signed [15:0]      cos_q15
);

    logic [1:0]  quad;
    logic [31:0] rem;

    // fold into plus or minus an eighth of a turn
    assign quad = 2'((angle + 32'h2000_0000) >> 30);
    assign rem  = angle - {quad, 30'b0};

    logic                 v_reg [1:CORDIC_STEPS];
    logic signed [XW-1:0] x_reg [1:CORDIC_STEPS];
    logic signed [XW-1:0] y_reg [1:CORDIC_STEPS];
    logic signed [ZW-1:0] z_reg [1:CORDIC_STEPS];
    logic [1:0]           q_reg [1:CORDIC_STEPS];

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_stage
        logic                 vi;
        logic signed [XW-1:0] xi;
        logic signed [XW-1:0] yi;
        logic signed [ZW-1:0] zi;
        logic [1:0]           qi;
        logic signed [ZW-1:0] at;

        if (i == 0)
        begin : g_first
            assign vi = in_valid;
            assign xi = CORDIC_GAIN_Q30;
            assign yi = '0;
            assign zi = $signed(rem);
            assign qi = quad;
        end
        else
        begin : g_rest
            assign vi = v_reg[i];
            assign xi = x_reg[i];
            assign yi = y_reg[i];
            assign zi = z_reg[i];
            assign qi = q_reg[i];
        end

        assign at = $signed({2'b00, ATAN_TURN[i]});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i+1] <= 1'b0;
            end
            else
            begin
                v_reg[i+1] <= vi;
            end
        end

        always_ff @(posedge clk)
        begin
            if (vi)
            begin
                if (zi >= 0)
                begin
                    x_reg[i+1] <= xi - (yi >>> i);
                    y_reg[i+1] <= yi + (xi >>> i);
                    z_reg[i+1] <= zi - at;
                end
                else
                begin
                    x_reg[i+1] <= xi + (yi >>> i);
                    y_reg[i+1] <= yi - (xi >>> i);
                    z_reg[i+1] <= zi + at;
                end
                q_reg[i+1] <= qi;
            end
        end
    end

    logic signed [15:0] s_q;
    logic signed [15:0] c_q;
    logic signed [15:0] sin_next;
    logic signed [15:0] cos_next;
    logic               out_valid_reg;
    logic signed [15:0] sin_reg;
    logic signed [15:0] cos_reg;

    assign s_q = to_q15(y_reg[CORDIC_STEPS]);
    assign c_q = to_q15(x_reg[CORDIC_STEPS]);

    always_comb
    begin
        case (q_reg[CORDIC_STEPS])
            2'd0:
            begin
                sin_next = s_q;
                cos_next = c_q;
            end
            2'd1:
            begin
                sin_next = c_q;
                cos_next = neg_sat(s_q);
            end
            2'd2:
            begin
                sin_next = neg_sat(s_q);
                cos_next = neg_sat(c_q);
            end
            default:
            begin
                sin_next = neg_sat(c_q);
                cos_next = s_q;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= v_reg[CORDIC_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (v_reg[CORDIC_STEPS])
        begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sin_q15   = sin_reg;
    assign cos_q15   = cos_reg;

endmodule
`default_nettype wire

[hw/rtl/lbp_norm.sv]
`default_nettype none
module lbp_norm import lbp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [15:0] range_mm,
    input  wire logic [15:0] raw,
    input  wire logic [23:0] ref_eff,
    output logic             out_valid,
    output logic [7:0]       norm
);

    // rhs = (raw*255)^2 * range_mm, built over three stages
    logic        f1_v_reg, f2_v_reg, f3_v_reg;
    logic [47:0] kk_reg;
    logic [15:0] dist_reg;
    logic [39:0] lo_reg, hi_reg;
    logic [63:0] rhs_reg;
    logic [23:0] k;

    assign k = {raw, 8'b0} - {8'b0, raw};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f1_v_reg <= 1'b0;
            f2_v_reg <= 1'b0;
            f3_v_reg <= 1'b0;
        end
        else
        begin
            f1_v_reg <= in_valid;
            f2_v_reg <= f1_v_reg;
            f3_v_reg <= f2_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            kk_reg   <= k * k;
            dist_reg <= range_mm;
        end
        if (f1_v_reg)
        begin
            lo_reg <= kk_reg[23:0] * dist_reg;
            hi_reg <= kk_reg[47:24] * dist_reg;
        end
        if (f2_v_reg)
        begin
            rhs_reg <= {hi_reg[39:0], 24'b0} + {24'b0, lo_reg};
        end
    end

    // bitwise search, msb first: square in one stage, compare in the next
    logic        a_v_reg   [NORM_BITS];
    logic [31:0] a_cand_reg[NORM_BITS];
    logic [63:0] a_sq_reg  [NORM_BITS];
    logic [7:0]  a_n_reg   [NORM_BITS];
    logic [31:0] a_m_reg   [NORM_BITS];
    logic [63:0] a_rhs_reg [NORM_BITS];
    logic        b_v_reg   [NORM_BITS];
    logic [7:0]  b_n_reg   [NORM_BITS];
    logic [31:0] b_m_reg   [NORM_BITS];
    logic [63:0] b_rhs_reg [NORM_BITS];

    for (genvar j = 0; j < NORM_BITS; j++)
    begin : g_bit
        localparam int B = NORM_BITS - 1 - j;
        logic        vj;
        logic [7:0]  nj;
        logic [31:0] mj;
        logic [63:0] rj;
        logic [31:0] cand;

        if (j == 0)
        begin : g_first
            assign vj = f3_v_reg;
            assign nj = '0;
            assign mj = '0;
            assign rj = rhs_reg;
        end
        else
        begin : g_rest
            assign vj = b_v_reg[j-1];
            assign nj = b_n_reg[j-1];
            assign mj = b_m_reg[j-1];
            assign rj = b_rhs_reg[j-1];
        end

        assign cand = mj + (32'(ref_eff) << B);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                a_v_reg[j] <= 1'b0;
                b_v_reg[j] <= 1'b0;
            end
            else
            begin
                a_v_reg[j] <= vj;
                b_v_reg[j] <= a_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (vj)
            begin
                a_cand_reg[j] <= cand;
                a_sq_reg[j]   <= cand * cand;
                a_n_reg[j]    <= nj;
                a_m_reg[j]    <= mj;
                a_rhs_reg[j]  <= rj;
            end
            if (a_v_reg[j])
            begin
                if (a_sq_reg[j] <= a_rhs_reg[j])
                begin
                    b_n_reg[j] <= a_n_reg[j] | (8'd1 << B);
                    b_m_reg[j] <= a_cand_reg[j];
                end
                else
                begin
                    b_n_reg[j] <= a_n_reg[j];
                    b_m_reg[j] <= a_m_reg[j];
                end
                b_rhs_reg[j] <= a_rhs_reg[j];
            end
        end
    end

    // delay line to line up with the pixel path
    logic       pad_v_reg [NORM_PAD];
    logic [7:0] pad_n_reg [NORM_PAD];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NORM_PAD; i++)
            begin
                pad_v_reg[i] <= 1'b0;
            end
        end
        else
        begin
            pad_v_reg[0] <= b_v_reg[NORM_BITS-1];
            for (int i = 1; i < NORM_PAD; i++)
            begin
                pad_v_reg[i] <= pad_v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pad_n_reg[0] <= b_n_reg[NORM_BITS-1];
        for (int i = 1; i < NORM_PAD; i++)
        begin
            pad_n_reg[i] <= pad_n_reg[i-1];
        end
    end

    assign out_valid = pad_v_reg[NORM_PAD-1];
    assign norm      = pad_n_reg[NORM_PAD-1];

endmodule
`default_nettype wire

[hw/rtl/lbp_place.sv]
`default_nettype none
module lbp_place import lbp_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [31:0]        ds,
    input  wire logic signed [15:0] trig,
    input  wire logic signed [15:0] center,
    output logic                    out_valid,
    output logic signed [15:0]      pix
);

    logic               v1_reg, v2_reg, v3_reg;
    logic signed [48:0] p_reg;
    logic signed [18:0] r_reg;
    logic signed [15:0] pix_reg;
    logic [47:0]        m;
    logic [17:0]        r;
    logic signed [XW-1:0] sum;

    assign m   = p_reg[48] ? 48'(-p_reg) : p_reg[47:0];
    assign r   = 18'((m + 48'h4000_0000) >> 31);
    assign sum = XW'(r_reg) + XW'(center);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid)
        begin
            p_reg <= $signed({1'b0, ds}) * trig;
        end
        if (v1_reg)
        begin
            // round half away from zero
            r_reg <= p_reg[48] ? -$signed({1'b0, r}) : $signed({1'b0, r});
        end
        if (v2_reg)
        begin
            pix_reg <= sat16(sum);
        end
    end

    assign out_valid = v3_reg;
    assign pix       = pix_reg;

endmodule
`default_nettype wire
